>>> rtl/slt_pkg.sv
// sorted linked table: shared constants, operation codes and types
// used by the channel interfaces, the compare unit and the top level
`default_nettype none

package slt_pkg;

  // fixed field widths of the channels
  localparam int KIND_W    = 3;
  localparam int KEY_W     = 64;
  localparam int PAYLOAD_W = 32;
  localparam int POS_W     = 5;
  localparam int CNT_W     = 5;

  // parameter defaults for the top level
  localparam int CAPACITY_DEF     = 16;
  localparam int KEY_BYTES_DEF    = 8;
  localparam int PAYLOAD_BITS_DEF = 32;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BY_POS = 3'd3;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd4;

  // outcome of one key comparison
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

`default_nettype wire

>>> rtl/slt_if.sv
// sorted linked table: valid/ready channel interfaces for the request and
// result sides; field widths come from slt_pkg
`default_nettype none

interface slt_in_if;
  import slt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [KEY_W-1:0]     key;
  logic [PAYLOAD_W-1:0] payload;
  logic [POS_W-1:0]     position;

  modport source (output valid, output kind, output key, output payload,
                  output position, input ready);
  modport sink   (input valid, input kind, input key, input payload,
                  input position, output ready);
endinterface

interface slt_out_if;
  import slt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [KEY_W-1:0]     found_key;
  logic [PAYLOAD_W-1:0] found_payload;
  logic [CNT_W-1:0]     entry_count;

  modport source (output valid, output ok, output found_key,
                  output found_payload, output entry_count, input ready);
  modport sink   (input valid, input ok, input found_key,
                  input found_payload, input entry_count, output ready);
endinterface

`default_nettype wire

>>> rtl/slt_ram.sv
// sorted linked table: generic single write, single read RAM with a
// registered read port; no dependencies
`default_nettype none

module slt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/slt_keycmp.sv
// sorted linked table: the shared key comparator used by the key-search list walk
// depends on slt_pkg for the result struct
`default_nettype none

module slt_keycmp #(
  parameter int KW = 64
) (
  input  wire logic [KW-1:0]     slot_key,
  input  wire logic [KW-1:0]     want_key,
  output slt_pkg::cmp_res_t      res
);
  import slt_pkg::*;

  always_comb begin
    res.lt = (slot_key < want_key);
    res.eq = (slot_key == want_key);
  end

endmodule

`default_nettype wire

>>> rtl/sorted_linked_table_unit.sv
// sorted linked table unit: up to CAPACITY (key, payload) records kept in
// ascending key order as a linked list in RAM, unused slots on a free list.
//
// Requests arrive on in_chan (valid/ready); one transaction carries kind,
// key, payload and position. Each request gives exactly one result
// transaction on out_chan: ok, found_key, found_payload, entry_count.
// The unit handles one request at a time; in_chan.ready is high only while
// the sequencer is idle. A request walks the list one record per cycle
// through the single read port of the link and record RAMs; key searches are
// compared by one shared key comparator. A finished result waits in the
// output register while the next request is accepted; if out_chan stalls,
// the following result is held in the sequencer until the register drains.
// After reset the free list is rebuilt by a pass over every slot of the link
// RAM, during which in_chan.ready stays low.
`default_nettype none

module sorted_linked_table_unit #(
  parameter int CAPACITY     = slt_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES    = slt_pkg::KEY_BYTES_DEF,
  parameter int PAYLOAD_BITS = slt_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  slt_in_if.sink     in_chan,
  slt_out_if.source  out_chan
);
  import slt_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int LW    = $clog2(CAPACITY + 1);
  localparam int CW    = LW;
  localparam int SW    = (CW > POS_W) ? CW : POS_W;
  localparam int KW    = KEY_BYTES * 8;
  localparam int PW    = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
  localparam int REC_W = KW + PW;

  localparam logic [LW-1:0] NIL      = LW'(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_STEP = SW'(CAPACITY);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_FIND, S_INS_A, S_INS_B, S_REM_A, S_REM_B, S_POS, S_RES
  } state_t;

  state_t            state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [PW-1:0]     pl_r, pl_nxt;
  logic [SW-1:0]     pos_r, pos_nxt;
  logic [LW-1:0]     cur_r, cur_nxt;
  logic [LW-1:0]     prev_r, prev_nxt;
  logic [LW-1:0]     hit_link_r, hit_link_nxt;
  logic [SW-1:0]     cnt_r, cnt_nxt;
  logic [LW-1:0]     used_head_r, used_head_nxt;
  logic [LW-1:0]     free_head_r, free_head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     raddr_r, raddr_nxt;
  logic [AW-1:0]     init_r, init_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [KW-1:0]     res_key_r, res_key_nxt;
  logic [PW-1:0]     res_pl_r, res_pl_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [KEY_W-1:0]     out_key_r, out_key_nxt;
  logic [PAYLOAD_W-1:0] out_pl_r, out_pl_nxt;
  logic [CNT_W-1:0]     out_cnt_r, out_cnt_nxt;

  // RAM ports
  logic             link_we;
  logic [AW-1:0]    link_waddr;
  logic [LW-1:0]    link_wdata;
  logic [LW-1:0]    link_rdata;
  logic             rec_we;
  logic [AW-1:0]    rec_waddr;
  logic [REC_W-1:0] rec_wdata;
  logic [REC_W-1:0] rec_rdata;

  logic [KW-1:0] rec_key;
  logic [PW-1:0] rec_pl;
  cmp_res_t      cmp;

  assign rec_key = rec_rdata[REC_W-1:PW];
  assign rec_pl  = rec_rdata[PW-1:0];

  slt_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (raddr_nxt),
    .rdata (link_rdata)
  );

  slt_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (raddr_nxt),
    .rdata (rec_rdata)
  );

  slt_keycmp #(.KW(KW)) u_cmp (
    .slot_key (rec_key),
    .want_key (key_r),
    .res      (cmp)
  );

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.ok            = out_ok_r;
  assign out_chan.found_key     = out_key_r;
  assign out_chan.found_payload = out_pl_r;
  assign out_chan.entry_count   = out_cnt_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    pl_nxt        = pl_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    hit_link_nxt  = hit_link_r;
    cnt_nxt       = cnt_r;
    used_head_nxt = used_head_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    raddr_nxt     = raddr_r;
    init_nxt      = init_r;
    res_ok_nxt    = res_ok_r;
    res_key_nxt   = res_key_r;
    res_pl_nxt    = res_pl_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_key_nxt   = out_key_r;
    out_pl_nxt    = out_pl_r;
    out_cnt_nxt   = out_cnt_r;
    link_we       = 1'b0;
    link_waddr    = '0;
    link_wdata    = '0;
    rec_we        = 1'b0;
    rec_waddr     = '0;
    rec_wdata     = '0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        // rebuild the free chain: slot i points at i+1, last at nil
        link_we    = 1'b1;
        link_waddr = init_r;
        link_wdata = LW'(init_r) + LW'(1);
        if (init_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          init_nxt = init_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_chan.valid) begin
          kind_nxt    = in_chan.kind;
          key_nxt     = in_chan.key[KW-1:0];
          pl_nxt      = in_chan.payload[PW-1:0];
          pos_nxt     = SW'(in_chan.position);
          prev_nxt    = NIL;
          cur_nxt     = used_head_r;
          cnt_nxt     = '0;
          raddr_nxt   = used_head_r[AW-1:0];
          res_ok_nxt  = 1'b0;
          res_key_nxt = '0;
          res_pl_nxt  = '0;
          state_nxt   = S_RES;
          unique case (in_chan.kind) inside
            KIND_INSERT: begin
              if (count_r < CAP_CNT && free_head_r < NIL) begin
                if (used_head_r == NIL) begin
                  raddr_nxt = free_head_r[AW-1:0];
                  state_nxt = S_INS_A;
                end else begin
                  state_nxt = S_FIND;
                end
              end
            end
            KIND_REMOVE, KIND_LOOKUP, KIND_UPDATE: begin
              if (count_r != '0 && used_head_r != NIL) begin
                state_nxt = S_FIND;
              end
            end
            KIND_BY_POS: begin
              if (in_chan.position != '0 && SW'(in_chan.position) <= SW'(count_r)
                  && used_head_r != NIL) begin
                cnt_nxt   = SW'(1);
                state_nxt = S_POS;
              end
            end
            default: begin
              state_nxt = S_RES;
            end
          endcase
        end
      end

      S_FIND: begin
        if (cnt_r < CAP_STEP && cmp.lt) begin
          prev_nxt = cur_r;
          cur_nxt  = link_rdata;
          cnt_nxt  = cnt_r + SW'(1);
          if (link_rdata == NIL) begin
            // ran off the end without a match
            if (kind_r == KIND_INSERT) begin
              raddr_nxt = free_head_r[AW-1:0];
              state_nxt = S_INS_A;
            end else begin
              state_nxt = S_RES;
            end
          end else begin
            raddr_nxt = link_rdata[AW-1:0];
          end
        end else begin
          hit_link_nxt = link_rdata;
          state_nxt    = S_RES;
          unique case (kind_r)
            KIND_INSERT: begin
              if (!cmp.eq) begin
                raddr_nxt = free_head_r[AW-1:0];
                state_nxt = S_INS_A;
              end
            end
            KIND_REMOVE: begin
              if (cmp.eq) begin
                res_key_nxt = rec_key;
                res_pl_nxt  = rec_pl;
                state_nxt   = S_REM_A;
              end
            end
            KIND_LOOKUP: begin
              if (cmp.eq) begin
                res_ok_nxt  = 1'b1;
                res_key_nxt = rec_key;
                res_pl_nxt  = rec_pl;
              end
            end
            KIND_UPDATE: begin
              if (cmp.eq) begin
                rec_we      = 1'b1;
                rec_waddr   = cur_r[AW-1:0];
                rec_wdata   = {key_r, pl_r};
                res_ok_nxt  = 1'b1;
                res_key_nxt = key_r;
                res_pl_nxt  = pl_r;
              end
            end
            default: begin
              state_nxt = S_RES;
            end
          endcase
        end
      end

      S_INS_A: begin
        // new slot taken from the free head, linked in front of cur
        free_head_nxt = link_rdata;
        link_we       = 1'b1;
        link_waddr    = raddr_r;
        link_wdata    = cur_r;
        rec_we        = 1'b1;
        rec_waddr     = raddr_r;
        rec_wdata     = {key_r, pl_r};
        state_nxt     = S_INS_B;
      end

      S_INS_B: begin
        if (prev_r != NIL) begin
          link_we    = 1'b1;
          link_waddr = prev_r[AW-1:0];
          link_wdata = LW'(raddr_r);
        end else begin
          used_head_nxt = LW'(raddr_r);
        end
        count_nxt   = count_r + CW'(1);
        res_ok_nxt  = 1'b1;
        res_key_nxt = key_r;
        res_pl_nxt  = pl_r;
        state_nxt   = S_RES;
      end

      S_REM_A: begin
        if (prev_r != NIL) begin
          link_we    = 1'b1;
          link_waddr = prev_r[AW-1:0];
          link_wdata = hit_link_r;
        end else begin
          used_head_nxt = hit_link_r;
        end
        state_nxt = S_REM_B;
      end

      S_REM_B: begin
        // freed slot goes on the front of the free list
        link_we       = 1'b1;
        link_waddr    = cur_r[AW-1:0];
        link_wdata    = free_head_r;
        free_head_nxt = cur_r;
        count_nxt     = count_r - CW'(1);
        res_ok_nxt    = 1'b1;
        state_nxt     = S_RES;
      end

      S_POS: begin
        if (cnt_r < pos_r) begin
          cur_nxt = link_rdata;
          cnt_nxt = cnt_r + SW'(1);
          if (link_rdata == NIL) begin
            state_nxt = S_RES;
          end else begin
            raddr_nxt = link_rdata[AW-1:0];
          end
        end else begin
          res_ok_nxt  = 1'b1;
          res_key_nxt = rec_key;
          res_pl_nxt  = rec_pl;
          state_nxt   = S_RES;
        end
      end

      S_RES: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_key_nxt   = KEY_W'(res_key_r);
          out_pl_nxt    = PAYLOAD_W'(res_pl_r);
          out_cnt_nxt   = CNT_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      used_head_r <= NIL;
      free_head_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      used_head_r <= used_head_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    pl_r       <= pl_nxt;
    pos_r      <= pos_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    hit_link_r <= hit_link_nxt;
    cnt_r      <= cnt_nxt;
    raddr_r    <= raddr_nxt;
    res_ok_r   <= res_ok_nxt;
    res_key_r  <= res_key_nxt;
    res_pl_r   <= res_pl_nxt;
    out_ok_r   <= out_ok_nxt;
    out_key_r  <= out_key_nxt;
    out_pl_r   <= out_pl_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

endmodule

`default_nettype wire
